>>> hw/rtl/mmcs_pkg.sv
package mmcs_pkg;

	// bounds and samples are held at this width; at most the 16-bit field width
	localparam int SampleBits = 16;
	localparam int FieldBits  = 16;
	localparam int OutBits    = 32;
	localparam int CfgBits    = 32;
	localparam int CfgIdxBits = 3;

	// signed difference of two samples
	localparam int DiffBits   = SampleBits + 1;
	// (s - low) * out_high + (high - s) * out_low
	localparam int ProdBits   = DiffBits + OutBits;
	localparam int MagBits    = ProdBits - 1;
	localparam int MulCntBits = $clog2(DiffBits);
	localparam int DivCntBits = $clog2(MagBits);

	localparam logic signed [OutBits-1:0] SatMax = {1'b0, {(OutBits-1){1'b1}}};
	localparam logic signed [OutBits-1:0] SatMin = {1'b1, {(OutBits-1){1'b0}}};

	localparam logic [CfgIdxBits-1:0] REG_MIN_SPAN   = 3'd0;
	localparam logic [CfgIdxBits-1:0] REG_OUT_LOW    = 3'd1;
	localparam logic [CfgIdxBits-1:0] REG_OUT_HIGH   = 3'd2;
	localparam logic [CfgIdxBits-1:0] REG_START_LOW  = 3'd3;
	localparam logic [CfgIdxBits-1:0] REG_START_HIGH = 3'd4;

	localparam logic [FieldBits-1:0]      RstMinSpan   = 16'd0;
	localparam logic signed [OutBits-1:0] RstOutLow    = 32'sd0;
	localparam logic signed [OutBits-1:0] RstOutHigh   = 32'sd23592960;
	localparam logic [FieldBits-1:0]      RstStartLow  = 16'hFFFF;
	localparam logic [FieldBits-1:0]      RstStartHigh = 16'h0000;

	typedef enum logic [1:0] {
		CMD_EXPAND  = 2'd0,
		CMD_CONVERT = 2'd1,
		CMD_LOAD    = 2'd2,
		CMD_RESTART = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                 command;
		logic [FieldBits-1:0] sample;
		logic [FieldBits-1:0] new_low;
		logic [FieldBits-1:0] new_high;
	} in_t;

	typedef struct packed {
		logic signed [OutBits-1:0] scaled_value;
		logic                      value_valid;
		logic                      calibrated;
		logic [FieldBits-1:0]      bound_low;
		logic [FieldBits-1:0]      bound_high;
	} out_t;

	// start and completion of one serial unit
	typedef struct packed {
		logic start;
		logic done;
	} unit_ctl_t;

endpackage

>>> hw/rtl/mmcs_if.sv
interface mmcs_in_if;
	logic           valid;
	logic           ready;
	mmcs_pkg::in_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface mmcs_out_if;
	logic           valid;
	logic           ready;
	mmcs_pkg::out_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/mmcs_mul.sv
module mmcs_mul (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	input  logic signed [mmcs_pkg::DiffBits-1:0]       diff_a,
	input  logic signed [mmcs_pkg::DiffBits-1:0]       diff_b,
	input  logic signed [mmcs_pkg::OutBits-1:0]        coef_a,
	input  logic signed [mmcs_pkg::OutBits-1:0]        coef_b,
	output logic                                       done,
	output logic signed [mmcs_pkg::ProdBits-1:0]       product
);

	localparam int PadBits = mmcs_pkg::ProdBits - mmcs_pkg::OutBits;

	logic                                    busy_q;
	logic                                    done_q;
	logic [mmcs_pkg::MulCntBits-1:0]         cnt_q;
	logic [mmcs_pkg::DiffBits-1:0]           a_q;
	logic [mmcs_pkg::DiffBits-1:0]           b_q;
	logic signed [mmcs_pkg::ProdBits-1:0]    ca_q;
	logic signed [mmcs_pkg::ProdBits-1:0]    cb_q;
	logic signed [mmcs_pkg::ProdBits-1:0]    acc_q;
	logic signed [mmcs_pkg::ProdBits-1:0]    pp;
	logic                                    last;

	assign last = cnt_q == mmcs_pkg::MulCntBits'(mmcs_pkg::DiffBits - 1);
	assign pp   = (a_q[0] ? ca_q : '0) + (b_q[0] ? cb_q : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// one multiplier bit per cycle; the top bit of a two's complement digit subtracts
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= diff_a;
			b_q   <= diff_b;
			ca_q  <= {{PadBits{coef_a[mmcs_pkg::OutBits-1]}}, coef_a};
			cb_q  <= {{PadBits{coef_b[mmcs_pkg::OutBits-1]}}, coef_b};
			acc_q <= '0;
		end else if (busy_q) begin
			a_q   <= a_q >> 1;
			b_q   <= b_q >> 1;
			ca_q  <= ca_q <<< 1;
			cb_q  <= cb_q <<< 1;
			acc_q <= last ? acc_q - pp : acc_q + pp;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

>>> hw/rtl/mmcs_div.sv
module mmcs_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [mmcs_pkg::ProdBits-1:0]   num,
	input  logic [mmcs_pkg::SampleBits-1:0]        den,
	output logic                                   done,
	output logic signed [mmcs_pkg::OutBits-1:0]    quotient
);

	localparam int SB = mmcs_pkg::SampleBits;
	localparam int MB = mmcs_pkg::MagBits;
	localparam int OB = mmcs_pkg::OutBits;

	logic                                busy_q;
	logic                                done_q;
	logic [mmcs_pkg::DivCntBits-1:0]     cnt_q;
	logic                                neg_q;
	logic [MB-1:0]                       q_q;
	logic [SB-1:0]                       rem_q;
	logic [SB-1:0]                       den_q;
	logic [mmcs_pkg::ProdBits-1:0]       mag;
	logic [SB:0]                         trial;
	logic [SB:0]                         diff;
	logic                                fits;
	logic                                last;
	logic                                pos_over;
	logic                                neg_over;

	assign last  = cnt_q == mmcs_pkg::DivCntBits'(MB - 1);
	assign mag   = num[mmcs_pkg::ProdBits-1] ? -num : num;
	assign trial = {rem_q, q_q[MB-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// restoring division on the magnitude: one quotient bit shifts in per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[mmcs_pkg::ProdBits-1];
			q_q   <= mag[MB-1:0];
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[SB-1:0] : trial[SB-1:0];
			q_q   <= {q_q[MB-2:0], fits};
		end
	end

	// truncation toward zero falls out of dividing the magnitude; saturate here
	assign pos_over = |q_q[MB-1:OB-1];
	assign neg_over = (|q_q[MB-1:OB]) || (q_q[OB-1] && (|q_q[OB-2:0]));

	always_comb begin
		if (neg_q) begin
			quotient = neg_over ? mmcs_pkg::SatMin : -$signed(q_q[OB-1:0]);
		end else begin
			quotient = pos_over ? mmcs_pkg::SatMax : $signed(q_q[OB-1:0]);
		end
	end

	assign done = done_q;

endmodule

>>> hw/rtl/minmax_calibrated_scaler.sv
// channel  dir  modport  payload                                          moves when
// item     in   sink     command, sample, new_low, new_high               valid & ready
// result   out  source   scaled_value, value_valid, calibrated, bounds    valid & ready
// wr_*     in   -        wr_index, wr_data (registers 0..4)               wr_en
//
// Expand, load, restart: ST_DONE registers the result once the output is free;
// new items wait for ST_IDLE. Calibrated convert: ST_MUL, ST_DIV, then ST_DONE,
// set by the 17-step multiplier and the 48-step divider, both bit-serial, in series.
// arst_n clears bounds to the start register reset values and empties the output.
// A stalled result holds the output register; the next item is still taken, and its
// result waits until the register frees up.
module minmax_calibrated_scaler (
	input  logic                               clk,
	input  logic                               arst_n,
	mmcs_in_if.sink                            item,
	mmcs_out_if.source                         result,
	input  logic                               wr_en,
	input  logic [mmcs_pkg::CfgIdxBits-1:0]    wr_index,
	input  logic [mmcs_pkg::CfgBits-1:0]       wr_data
);

	localparam int SB = mmcs_pkg::SampleBits;
	localparam int FB = mmcs_pkg::FieldBits;
	localparam int OB = mmcs_pkg::OutBits;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                                state_q;
	logic [SB-1:0]                         low_q;
	logic [SB-1:0]                         high_q;
	logic [FB-1:0]                         min_span_q;
	logic signed [OB-1:0]                  out_low_q;
	logic signed [OB-1:0]                  out_high_q;
	logic [FB-1:0]                         start_low_q;
	logic [FB-1:0]                         start_high_q;
	logic signed [OB-1:0]                  scaled_q;
	logic                                  vv_q;
	mmcs_pkg::out_t                        out_q;
	logic                                  out_valid_q;

	logic                                  accept;
	logic                                  out_free;
	logic                                  cal_ok;
	logic [SB-1:0]                         span;
	logic [SB-1:0]                         sample_s;
	logic signed [mmcs_pkg::DiffBits-1:0]  diff_a;
	logic signed [mmcs_pkg::DiffBits-1:0]  diff_b;
	logic signed [mmcs_pkg::ProdBits-1:0]  product;
	logic signed [OB-1:0]                  quotient;
	mmcs_pkg::unit_ctl_t                   mul_ctl;
	mmcs_pkg::unit_ctl_t                   div_ctl;

	assign item.ready = state_q == ST_IDLE;
	assign accept     = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;

	assign sample_s = item.payload.sample[SB-1:0];
	assign span     = high_q - low_q;
	assign cal_ok   = (high_q > low_q) && (FB'(span) > min_span_q);

	assign diff_a = $signed({1'b0, sample_s}) - $signed({1'b0, low_q});
	assign diff_b = $signed({1'b0, high_q}) - $signed({1'b0, sample_s});

	assign mul_ctl.start = accept && (item.payload.command == mmcs_pkg::CMD_CONVERT) && cal_ok;
	assign div_ctl.start = mul_ctl.done;

	mmcs_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_ctl.start),
		.diff_a  (diff_a),
		.diff_b  (diff_b),
		.coef_a  (out_high_q),
		.coef_b  (out_low_q),
		.done    (mul_ctl.done),
		.product (product)
	);

	mmcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_ctl.start),
		.num      (product),
		.den      (span),
		.done     (div_ctl.done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_span_q   <= mmcs_pkg::RstMinSpan;
			out_low_q    <= mmcs_pkg::RstOutLow;
			out_high_q   <= mmcs_pkg::RstOutHigh;
			start_low_q  <= mmcs_pkg::RstStartLow;
			start_high_q <= mmcs_pkg::RstStartHigh;
		end else if (wr_en) begin
			unique case (wr_index)
				mmcs_pkg::REG_MIN_SPAN:   min_span_q   <= wr_data[FB-1:0];
				mmcs_pkg::REG_OUT_LOW:    out_low_q    <= $signed(wr_data[OB-1:0]);
				mmcs_pkg::REG_OUT_HIGH:   out_high_q   <= $signed(wr_data[OB-1:0]);
				mmcs_pkg::REG_START_LOW:  start_low_q  <= wr_data[FB-1:0];
				mmcs_pkg::REG_START_HIGH: start_high_q <= wr_data[FB-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			low_q       <= mmcs_pkg::RstStartLow[SB-1:0];
			high_q      <= mmcs_pkg::RstStartHigh[SB-1:0];
			scaled_q    <= '0;
			vv_q        <= 1'b0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// in ST_DONE the output register is either refilled or still stalled
			if (result.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						scaled_q <= '0;
						vv_q     <= 1'b0;
						state_q  <= mul_ctl.start ? ST_MUL : ST_DONE;
						unique case (item.payload.command)
							mmcs_pkg::CMD_EXPAND: begin
								if (sample_s < low_q) begin
									low_q <= sample_s;
								end
								if (sample_s > high_q) begin
									high_q <= sample_s;
								end
							end
							// the multiplier starts off the accepting edge
							mmcs_pkg::CMD_CONVERT: ;
							mmcs_pkg::CMD_LOAD: begin
								low_q  <= item.payload.new_low[SB-1:0];
								high_q <= item.payload.new_high[SB-1:0];
							end
							mmcs_pkg::CMD_RESTART: begin
								low_q  <= start_low_q[SB-1:0];
								high_q <= start_high_q[SB-1:0];
							end
							default: ;
						endcase
					end
				end
				ST_MUL: begin
					if (mul_ctl.done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_ctl.done) begin
						scaled_q <= quotient;
						vv_q     <= 1'b1;
						state_q  <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the output register frees up
					if (out_free) begin
						out_q.scaled_value <= scaled_q;
						out_q.value_valid  <= vv_q;
						out_q.calibrated   <= cal_ok;
						out_q.bound_low    <= FB'(low_q);
						out_q.bound_high   <= FB'(high_q);
						out_valid_q        <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted beat did not start work");

	a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_ctl.done |-> state_q == ST_MUL)
		else $error("multiplier finished outside the multiply phase");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide phase");

	a_value_needs_cal: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.payload.value_valid) |-> result.payload.calibrated)
		else $error("converted value reported without valid calibration");

	a_cal_bounds_order: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.payload.calibrated)
			|-> result.payload.bound_high > result.payload.bound_low)
		else $error("calibrated flag with bounds out of order");

endmodule
